/* design/msfb_pkg.sv */
package msfb_pkg;

  // Default configuration of the core.
  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;

  // Fixed field widths.
  localparam int LETTER_W = 5;
  localparam int BORDER_W = 10;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_STEP,
    ST_FINAL,
    ST_EMIT
  } state_t;

endpackage

/* design/min_string_from_borders_core.sv */
// A transaction at position zero or on a full store goes straight to ST_EMIT; a nonzero
// border passes through ST_COPY, and a zero border walks its chain in ST_STEP, one link at a
// time through the single read port of each store, before ST_FINAL. A new transaction is
// taken only once the sequencer is back in ST_IDLE.
// Reset (rst, synchronous, active high) clears the position, the sequencer and the output
// valid; the letter and border stores are not cleared and need no clearing pass.
module min_string_from_borders_core #(
  parameter int MAX_LEN  = msfb_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = msfb_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_new,
  input  logic [msfb_pkg::BORDER_W-1:0] border_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [msfb_pkg::LETTER_W-1:0] letter,
  output logic                          bad_border,
  output logic                          no_free_letter,
  output logic                          overflow
);

  // AW indexes the stores; PW also holds MAX_LEN itself; CW is wide enough to compare
  // a border value against a position.
  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int BW = msfb_pkg::BORDER_W;
  localparam int LW = msfb_pkg::LETTER_W;
  localparam int CW = (PW > BW) ? PW : BW;

  msfb_pkg::state_t state, state_next;

  // Position of the next letter to produce, and the context of the transaction at work.
  logic [PW-1:0]       position;
  logic [AW-1:0]       idx;
  logic [BW-1:0]       b_eff;
  logic [ALPHABET-1:0] mask;
  logic                have_letter;

  // Staged result, moved into the output register in ST_EMIT.
  logic [LW-1:0] res_letter;
  logic          res_bad;
  logic          res_nofree;
  logic          res_ovf;

  // Store ports.
  logic          lt_we, lt_re, bd_we, bd_re;
  logic [AW-1:0] lt_waddr, lt_raddr, bd_waddr, bd_raddr;
  logic [LW-1:0] lt_wdata, lt_rdata;
  logic [BW-1:0] bd_wdata, bd_rdata;

  logic          accept;
  logic          out_free;
  logic [PW-1:0] pos_eff;
  logic          ovf_now;
  logic          pos0_now;
  logic          bad_now;
  logic [BW-1:0] b_acc;
  logic          walk;
  logic [ALPHABET-1:0] letter_bit;
  logic [ALPHABET-1:0] mask_step;
  logic [ALPHABET-1:0] mask_final;
  logic          found;
  logic [LW-1:0] pick;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // A start of a new string restarts the position at zero within this transaction.
  assign pos_eff  = start_new ? '0 : position;
  assign ovf_now  = (pos_eff >= PW'(MAX_LEN));
  assign pos0_now = (pos_eff == '0);
  // A border above the position is treated as zero; flagged save at position zero or overflow.
  assign bad_now  = (CW'(border_len) > CW'(pos_eff));
  assign b_acc    = bad_now ? '0 : border_len;

  // During the chain walk the border just read names the next link; it continues the walk
  // only while it is nonzero and below the current index.
  assign walk = (bd_rdata != '0) && (CW'(bd_rdata) < CW'(idx));

  // One-hot of the letter that was read; a letter outside the alphabet forbids nothing.
  always_comb begin
    for (int k = 0; k < ALPHABET; k++) begin
      letter_bit[k] = (lt_rdata == LW'(k));
    end
  end

  assign mask_step  = have_letter ? (mask | letter_bit) : mask;
  assign mask_final = mask | letter_bit;

  // Lowest letter that no border of the chain would continue.
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int k = ALPHABET - 1; k >= 0; k--) begin
      if (!mask_final[k]) begin
        found = 1'b1;
        pick  = LW'(k);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      msfb_pkg::ST_IDLE: begin
        if (accept) begin
          if (ovf_now || pos0_now) begin
            state_next = msfb_pkg::ST_EMIT;
          end else if (b_acc != '0) begin
            state_next = msfb_pkg::ST_COPY;
          end else begin
            state_next = msfb_pkg::ST_STEP;
          end
        end
      end
      msfb_pkg::ST_COPY:  state_next = msfb_pkg::ST_EMIT;
      msfb_pkg::ST_STEP:  state_next = walk ? msfb_pkg::ST_STEP : msfb_pkg::ST_FINAL;
      msfb_pkg::ST_FINAL: state_next = msfb_pkg::ST_EMIT;
      msfb_pkg::ST_EMIT:  state_next = out_free ? msfb_pkg::ST_IDLE : msfb_pkg::ST_EMIT;
      default:            state_next = msfb_pkg::ST_IDLE;
    endcase
  end

  // Handshake and store control.
  always_comb begin
    in_ready = 1'b0;
    lt_we    = 1'b0;
    lt_waddr = idx;
    lt_wdata = '0;
    lt_re    = 1'b0;
    lt_raddr = '0;
    bd_we    = 1'b0;
    bd_waddr = idx;
    bd_wdata = b_eff;
    bd_re    = 1'b0;
    bd_raddr = '0;
    case (state)
      msfb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && !ovf_now) begin
          if (pos0_now) begin
            // Position zero: letter a and border zero.
            lt_we    = 1'b1;
            lt_waddr = '0;
            bd_we    = 1'b1;
            bd_waddr = '0;
            bd_wdata = '0;
          end else if (b_acc != '0) begin
            // Nonzero border: fetch the letter that the border continues.
            lt_re    = 1'b1;
            lt_raddr = AW'(b_acc - 1'b1);
          end else begin
            // Zero border: the chain starts at the previous position's border.
            bd_re    = 1'b1;
            bd_raddr = AW'(pos_eff - 1'b1);
          end
        end
      end
      msfb_pkg::ST_COPY: begin
        lt_we    = 1'b1;
        lt_wdata = lt_rdata;
        bd_we    = 1'b1;
      end
      msfb_pkg::ST_STEP: begin
        // Fetch the letter after this border and the next link together; at the end
        // of the chain fetch the first letter of the string.
        lt_re = 1'b1;
        if (walk) begin
          lt_raddr = AW'(bd_rdata);
          bd_re    = 1'b1;
          bd_raddr = AW'(bd_rdata - 1'b1);
        end
      end
      msfb_pkg::ST_FINAL: begin
        lt_we    = 1'b1;
        lt_wdata = pick;
        bd_we    = 1'b1;
      end
      msfb_pkg::ST_EMIT: begin
        in_ready = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msfb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Position and walk control.
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      mask        <= '0;
      have_letter <= 1'b0;
    end else begin
      case (state)
        msfb_pkg::ST_IDLE: begin
          if (accept) begin
            mask        <= '0;
            have_letter <= 1'b0;
            if (!ovf_now && pos0_now) begin
              position <= PW'(1);
            end else if (start_new) begin
              position <= '0;
            end
          end
        end
        msfb_pkg::ST_STEP: begin
          mask        <= mask_step;
          have_letter <= 1'b1;
        end
        msfb_pkg::ST_COPY, msfb_pkg::ST_FINAL: begin
          position <= PW'(idx) + 1'b1;
        end
        default: begin
          position <= position;
        end
      endcase
    end
  end

  // Transaction context and staged result.
  always_ff @(posedge clk) begin
    if (state == msfb_pkg::ST_IDLE && accept) begin
      idx        <= pos_eff[AW-1:0];
      b_eff      <= b_acc;
      res_letter <= '0;
      res_bad    <= !ovf_now && !pos0_now && bad_now;
      res_nofree <= 1'b0;
      res_ovf    <= ovf_now;
    end else if (state == msfb_pkg::ST_COPY) begin
      res_letter <= lt_rdata;
    end else if (state == msfb_pkg::ST_FINAL) begin
      res_letter <= pick;
      res_nofree <= !found;
    end
  end

  // Output register; the input side keeps working while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == msfb_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == msfb_pkg::ST_EMIT && out_free) begin
      letter         <= res_letter;
      bad_border     <= res_bad;
      no_free_letter <= res_nofree;
      overflow       <= res_ovf;
    end
  end

  msfb_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (LW)
  ) u_letter_store (
    .clk   (clk),
    .we    (lt_we),
    .waddr (lt_waddr),
    .wdata (lt_wdata),
    .re    (lt_re),
    .raddr (lt_raddr),
    .rdata (lt_rdata)
  );

  msfb_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (BW)
  ) u_border_store (
    .clk   (clk),
    .we    (bd_we),
    .waddr (bd_waddr),
    .wdata (bd_wdata),
    .re    (bd_re),
    .raddr (bd_raddr),
    .rdata (bd_rdata)
  );

endmodule

/* design/msfb_ram.sv */
module msfb_ram #(
  parameter int DEPTH = msfb_pkg::MAX_LEN_DEF,
  parameter int WIDTH = msfb_pkg::BORDER_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/msfb_checker.sv */
module msfb_checker #(
  parameter int ALPHABET = msfb_pkg::ALPHABET_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [msfb_pkg::LETTER_W-1:0] letter,
  input logic                          bad_border,
  input logic                          no_free_letter,
  input logic                          overflow
);

  // A stalled result keeps its valid, letter and overflow flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(letter) && $stable(overflow))
    else $error("result changed while stalled");

  // A full store reports nothing else.
  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> letter == '0 && !bad_border && !no_free_letter)
    else $error("overflow result carries other fields");

  // With no free letter the letter is a.
  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_free_letter |-> letter == '0)
    else $error("no free letter but letter nonzero");

  // Every letter lies in the alphabet.
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> letter < msfb_pkg::LETTER_W'(ALPHABET))
    else $error("letter outside alphabet");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind min_string_from_borders_core msfb_checker #(
  .ALPHABET (ALPHABET)
) u_msfb_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .letter         (letter),
  .bad_border     (bad_border),
  .no_free_letter (no_free_letter),
  .overflow       (overflow)
);
